@@ src/square_matrix_add_sub_mul_top_assert.svh @@
// assertion macros for the matrix block, sampled on clk, off during rst
`ifndef SQUARE_MATRIX_ADD_SUB_MUL_TOP_ASSERT_SVH
`define SQUARE_MATRIX_ADD_SUB_MUL_TOP_ASSERT_SVH

// same-cycle implication
`define SMAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/smas_pkg.sv @@
package smas_pkg;

  localparam int DIM_W      = 4;
  localparam int MODE_W     = 2;
  localparam int ELEM_W     = 16;
  localparam int OUT_W      = 36;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // operation codes
  localparam logic [MODE_W-1:0] OP_ADD = 2'd0;
  localparam logic [MODE_W-1:0] OP_SUB = 2'd1;
  localparam logic [MODE_W-1:0] OP_MUL = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM     = 1'b1;

  localparam logic [MODE_W-1:0] OP_MODE_RESET = OP_ADD;
  localparam logic [DIM_W-1:0]  DIM_RESET     = 4'd8;

  typedef struct packed {
    logic signed [ELEM_W-1:0] a_elem;
    logic signed [ELEM_W-1:0] b_elem;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_value;
    logic                    last_elem;
  } out_item_t;

  // tag that travels with each read through the arithmetic pipe
  typedef struct packed {
    logic valid;
    logic first;
    logic last_k;
    logic last_elem;
  } issue_t;

endpackage

@@ src/square_matrix_add_sub_mul_top.sv @@
// channel   direction  handshake              payload
// in        input      start & !busy          in_data   (a_elem, b_elem)
// out       output     out_strobe, one cycle  out_data  (out_value, last_elem)
// cfg       input      cfg_we                 cfg_idx, cfg_wdata
//
// each element pair beat is taken with start while idle; the n*n-th pair starts the run
// after it, busy stays high until the run is done and the pipe has drained; the single
// multiply-accumulate unit does one term a cycle
// results come one per cycle (add, subtract) or one per element after its n terms (multiply)
// reset is synchronous; stores need no clearing, so start is taken right away
// the receiver cannot stall: every result is valid for exactly one cycle
`include "square_matrix_add_sub_mul_top_assert.svh"

module square_matrix_add_sub_mul_top #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  smas_pkg::in_item_t                  in_data,
  output logic                                out_strobe,
  output smas_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [smas_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [smas_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import smas_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [MODE_W-1:0] op_mode;
  logic [DIM_W-1:0]  dim;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     a_addr;
  logic [AW-1:0]     b_addr;
  logic [ELEM_W-1:0] a_rd;
  logic [ELEM_W-1:0] b_rd;
  logic              pipe_busy;
  issue_t            issue;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode <= OP_MODE_RESET;
      dim     <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OP_MODE: op_mode <= cfg_wdata[MODE_W-1:0];
        REG_DIM:     dim     <= cfg_wdata[DIM_W-1:0];
        default:     ;
      endcase
    end
  end

  smas_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op_mode   (op_mode),
    .dim       (dim),
    .pipe_busy (pipe_busy),
    .busy      (busy),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .a_addr    (a_addr),
    .b_addr    (b_addr),
    .issue     (issue)
  );

  // element stores for A and B
  smas_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.a_elem),
    .rd_addr (a_addr),
    .rd_data (a_rd)
  );

  smas_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.b_elem),
    .rd_addr (b_addr),
    .rd_data (b_rd)
  );

  smas_alu u_alu (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .op_mode    (op_mode),
    .a_rd       (a_rd),
    .b_rd       (b_rd),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .pipe_busy  (pipe_busy)
  );

  // checks
  `SMAS_ASSERT_NOW(a_strobe_in_run, out_strobe, busy, "result beat while idle")
  `SMAS_ASSERT_NEXT(a_busy_needs_start, !busy && !start, !busy, "busy without a beat")
  `SMAS_ASSERT_NEXT(a_last_ends_run, out_strobe && out_data.last_elem, !out_strobe,
    "result beat after the last element")

endmodule

@@ src/smas_ram.sv @@
module smas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/smas_alu.sv @@
module smas_alu (
  input  logic                                  clk,
  input  logic                                  rst,
  input  smas_pkg::issue_t                      issue,
  input  logic [smas_pkg::MODE_W-1:0]           op_mode,
  input  logic [smas_pkg::ELEM_W-1:0]           a_rd,
  input  logic [smas_pkg::ELEM_W-1:0]           b_rd,
  output logic                                  out_strobe,
  output smas_pkg::out_item_t                   out_data,
  output logic                                  pipe_busy
);
  import smas_pkg::*;

  issue_t                    tag1;
  issue_t                    tag2;
  logic signed [OUT_W-1:0]   term;
  logic signed [OUT_W-1:0]   term_next;
  logic signed [OUT_W-1:0]   acc;
  logic signed [OUT_W-1:0]   acc_next;
  logic                      last_elem;
  logic signed [ELEM_W:0]    sum_ab;
  logic signed [ELEM_W:0]    dif_ab;
  logic signed [2*ELEM_W-1:0] prod;

  // operand math on the registered memory data
  always_comb begin
    sum_ab = {a_rd[ELEM_W-1], a_rd} + {b_rd[ELEM_W-1], b_rd};
    dif_ab = {a_rd[ELEM_W-1], a_rd} - {b_rd[ELEM_W-1], b_rd};
    prod   = $signed(a_rd) * $signed(b_rd);
    unique case (op_mode)
      OP_ADD:  term_next = {{(OUT_W-ELEM_W-9){sum_ab[ELEM_W]}}, sum_ab, 8'b0};
      OP_SUB:  term_next = {{(OUT_W-ELEM_W-9){dif_ab[ELEM_W]}}, dif_ab, 8'b0};
      OP_MUL:  term_next = {{(OUT_W-2*ELEM_W){prod[2*ELEM_W-1]}}, prod};
      default: term_next = '0;
    endcase
  end

  // accumulate, restart on the first term of an element
  assign acc_next = tag2.first ? term : acc + term;

  // tag pipe, aligned with memory latency and the term register
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1       <= '0;
      tag2       <= '0;
      out_strobe <= 1'b0;
    end else begin
      tag1       <= issue;
      tag2       <= tag1;
      out_strobe <= tag2.valid && tag2.last_k;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tag1.valid) begin
      term <= term_next;
    end
    if (tag2.valid) begin
      acc       <= acc_next;
      last_elem <= tag2.last_elem;
    end
  end

  assign out_data.out_value = acc;
  assign out_data.last_elem = last_elem;
  assign pipe_busy          = tag1.valid || tag2.valid || out_strobe;

endmodule

@@ src/smas_seq.sv @@
module smas_seq #(
  parameter int MAX_DIM = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [smas_pkg::MODE_W-1:0]           op_mode,
  input  logic [smas_pkg::DIM_W-1:0]            dim,
  input  logic                                  pipe_busy,
  output logic                                  busy,
  output logic                                  wr_en,
  output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
  output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] a_addr,
  output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] b_addr,
  output smas_pkg::issue_t                      issue
);
  import smas_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = 2 * DIM_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   load_count;
  logic [CNT_W-1:0]   load_count_next;
  logic [DIM_W-1:0]   i_idx, i_idx_next;
  logic [DIM_W-1:0]   j_idx, j_idx_next;
  logic [DIM_W-1:0]   k_idx, k_idx_next;
  logic [AW-1:0]      row_base, row_base_next;
  logic [AW-1:0]      kn, kn_next;
  logic [DIM_W-1:0]   n;
  logic [DIM_W-1:0]   n_m1;
  logic [2*DIM_W-1:0] total;
  logic               load_done;
  logic               accept;
  logic               is_mul;
  logic               last_k;
  logic               last_j;
  logic               last_i;

  // active dimension: zero reads as one, large values clip to the bound
  always_comb begin
    priority if (dim == '0) begin
      n = DIM_W'(1);
    end else if (32'(dim) > MAX_DIM) begin
      n = DIM_W'(MAX_DIM);
    end else begin
      n = dim;
    end
  end

  assign n_m1      = n - DIM_W'(1);
  assign total     = n * n;
  assign accept    = start && (state == ST_IDLE);
  assign load_done = (CMP_W'(load_count) + CMP_W'(1)) >= CMP_W'(total);
  assign is_mul    = (op_mode == OP_MUL);
  assign last_k    = !is_mul || (k_idx == n_m1);
  assign last_j    = (j_idx == n_m1);
  assign last_i    = (i_idx == n_m1);

  // store port drive
  assign wr_en   = accept;
  assign wr_addr = load_count[AW-1:0];
  assign a_addr  = row_base + (is_mul ? AW'(k_idx) : AW'(j_idx));
  assign b_addr  = is_mul ? (kn + AW'(j_idx)) : (row_base + AW'(j_idx));

  assign issue.valid     = (state == ST_RUN);
  assign issue.first     = (k_idx == '0);
  assign issue.last_k    = last_k;
  assign issue.last_elem = last_k && last_j && last_i;

  assign busy = (state != ST_IDLE);

  // sequencer: load beats, then one read pair per cycle over i, j (and k for multiply), then drain
  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    i_idx_next      = i_idx;
    j_idx_next      = j_idx;
    k_idx_next      = k_idx;
    row_base_next   = row_base;
    kn_next         = kn;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (load_done) begin
            state_next      = ST_RUN;
            load_count_next = '0;
            i_idx_next      = '0;
            j_idx_next      = '0;
            k_idx_next      = '0;
            row_base_next   = '0;
            kn_next         = '0;
          end else begin
            load_count_next = load_count + CNT_W'(1);
          end
        end
      end
      ST_RUN: begin
        if (!last_k) begin
          k_idx_next = k_idx + DIM_W'(1);
          kn_next    = kn + AW'(n);
        end else begin
          k_idx_next = '0;
          kn_next    = '0;
          if (!last_j) begin
            j_idx_next = j_idx + DIM_W'(1);
          end else begin
            j_idx_next    = '0;
            i_idx_next    = i_idx + DIM_W'(1);
            row_base_next = row_base + AW'(n);
            if (last_i) begin
              state_next = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      load_count <= '0;
      i_idx      <= '0;
      j_idx      <= '0;
      k_idx      <= '0;
      row_base   <= '0;
      kn         <= '0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      i_idx      <= i_idx_next;
      j_idx      <= j_idx_next;
      k_idx      <= k_idx_next;
      row_base   <= row_base_next;
      kn         <= kn_next;
    end
  end

endmodule
